/* sv/coa_pkg.sv */
// Shared constants and types for the comment owner attach block.
// No dependencies; used by comment_owner_attach_top, coa_scan and the bench.
`timescale 1ns / 1ps

package coa_pkg;

  // Default sizing
  localparam int unsigned MAX_NODES   = 1024;
  localparam int unsigned OFFSET_BITS = 16;

  // Width of node ids on the result and configuration ports
  localparam int unsigned ID_W = 10;

  // Input command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_TOKEN = 2'd2;

  // Token classes
  localparam logic [1:0] CLS_REAL    = 2'd0;
  localparam logic [1:0] CLS_SPACE   = 2'd1;
  localparam logic [1:0] CLS_COMMENT = 2'd2;

  // Status of the neighbor search unit toward the control logic
  typedef struct packed {
    logic busy;
    logic done;
    logic has_prec;
    logic has_foll;
  } scan_status_t;

endpackage

/* sv/comment_owner_attach_top.sv */
// Comment owner attach: a clear, load or non-comment token request is taken
// without stalling the input. A comment request stalls the input and scans all
// loaded node ranges through the range store, one per cycle; the memory read
// port sets that pace. Its result waits while the output register is stalled,
// and the next request is taken once the result has entered that register.
// Reset (rst_ni, async low) clears node list, history and root_node.
`timescale 1ns / 1ps

module comment_owner_attach_top #(
  parameter int unsigned MAX_NODES   = coa_pkg::MAX_NODES,
  parameter int unsigned OFFSET_BITS = coa_pkg::OFFSET_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [coa_pkg::ID_W-1:0] cfg_root_node_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [OFFSET_BITS-1:0]   range_first_i,
  input  logic [OFFSET_BITS-1:0]   range_last_i,
  input  logic [1:0]               token_class_i,
  input  logic [OFFSET_BITS-1:0]   token_offset_i,
  input  logic [OFFSET_BITS-1:0]   token_length_i,
  input  logic                     token_has_newline_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [coa_pkg::ID_W-1:0] owner_node_o,
  output logic                     is_trailing_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned ID_W   = coa_pkg::ID_W;

  logic [ID_W-1:0]        root_q;
  logic [CNT_W-1:0]       count_q;
  logic                   had_real_q;
  logic                   gap_nl_q;
  logic                   trail_q;
  logic                   out_valid_q;
  logic [ID_W-1:0]        owner_q;
  logic                   is_trail_q;

  logic                   accept;
  logic                   is_load;
  logic                   is_comment;
  logic                   mem_we;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [2*OFFSET_BITS-1:0] mem_rdata;
  logic [OFFSET_BITS:0]   tok_end;
  logic                   ack;
  logic [ADDR_W-1:0]      prec_id;
  logic [ADDR_W-1:0]      foll_id;
  logic [ADDR_W-1:0]      win_id;
  logic [ADDR_W+ID_W-1:0] win_ext;
  logic [ID_W-1:0]        owner_d;
  coa_pkg::scan_status_t  scan_st;

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = scan_st.busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_load     = accept && (cmd_i == coa_pkg::CMD_LOAD);
  assign is_comment  = accept && (cmd_i == coa_pkg::CMD_TOKEN) &&
                       (token_class_i == coa_pkg::CLS_COMMENT);
  assign mem_we      = is_load && (count_q < CNT_W'(MAX_NODES));
  assign tok_end     = {1'b0, token_offset_i} + {1'b0, token_length_i};

  // Range store
  coa_mem #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (ADDR_W),
    .DATA_W (2 * OFFSET_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({range_first_i, range_last_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Neighbor search
  coa_scan #(
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W),
    .OFF_W  (OFFSET_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (is_comment),
    .ack_i     (ack),
    .off_i     (token_offset_i),
    .end_i     (tok_end),
    .count_i   (count_q),
    .re_o      (mem_re),
    .raddr_o   (mem_raddr),
    .rdata_i   (mem_rdata),
    .status_o  (scan_st),
    .prec_id_o (prec_id),
    .foll_id_o (foll_id)
  );

  // Owner selection; node ids keep their low bits at the result width
  assign win_id  = trail_q ? prec_id : foll_id;
  assign win_ext = {{ID_W{1'b0}}, win_id};
  assign owner_d = (scan_st.has_prec && scan_st.has_foll) ? win_ext[ID_W-1:0] : root_q;
  assign ack     = scan_st.done && (!out_valid_q || !out_stall_i);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_q <= cfg_root_node_i;
    end
  end

  // Statement and token history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      had_real_q <= 1'b0;
      gap_nl_q   <= 1'b0;
      trail_q    <= 1'b0;
    end else if (accept) begin
      unique case (cmd_i)
        coa_pkg::CMD_CLEAR: begin
          count_q    <= '0;
          had_real_q <= 1'b0;
          gap_nl_q   <= 1'b0;
        end
        coa_pkg::CMD_LOAD: begin
          if (mem_we) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        coa_pkg::CMD_TOKEN: begin
          priority if (token_class_i == coa_pkg::CLS_SPACE) begin
            if (token_has_newline_i) begin
              gap_nl_q <= 1'b1;
            end
          end else if (token_class_i == coa_pkg::CLS_COMMENT) begin
            trail_q <= had_real_q && !gap_nl_q;
            if (token_has_newline_i) begin
              gap_nl_q <= 1'b1;
            end
          end else begin
            // real token, unused class counts as real
            had_real_q <= 1'b1;
            gap_nl_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      owner_q     <= '0;
      is_trail_q  <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
      owner_q     <= owner_d;
      is_trail_q  <= trail_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign owner_node_o  = owner_q;
  assign is_trailing_o = is_trail_q;

endmodule

/* sv/coa_mem.sv */
// Node range store: one write port, one read port, registered read data.
// Depends on nothing; instantiated by comment_owner_attach_top.
`timescale 1ns / 1ps

module coa_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/coa_scan.sv */
// Neighbor search unit: streams the node ranges out of the range store and
// keeps the best preceding and following node. Depends on coa_pkg.
`timescale 1ns / 1ps

module coa_scan #(
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned CNT_W  = 11,
  parameter int unsigned OFF_W  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    ack_i,
  input  logic [OFF_W-1:0]        off_i,
  input  logic [OFF_W:0]          end_i,
  input  logic [CNT_W-1:0]        count_i,
  output logic                    re_o,
  output logic [ADDR_W-1:0]       raddr_o,
  input  logic [2*OFF_W-1:0]      rdata_i,
  output coa_pkg::scan_status_t   status_o,
  output logic [ADDR_W-1:0]       prec_id_o,
  output logic [ADDR_W-1:0]       foll_id_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  idx_q;
  logic              rv_q;
  logic [ADDR_W-1:0] rid_q;
  logic [OFF_W-1:0]  off_q;
  logic [OFF_W:0]    end_q;

  logic              pfound_q;
  logic [OFF_W-1:0]  pend_q;
  logic [OFF_W:0]    pspan_q;
  logic [ADDR_W-1:0] pid_q;
  logic              ffound_q;
  logic [OFF_W-1:0]  fstart_q;
  logic [OFF_W:0]    fspan_q;
  logic [ADDR_W-1:0] fid_q;

  logic              issue;
  logic [OFF_W-1:0]  first_v;
  logic [OFF_W-1:0]  last_v;
  logic [OFF_W:0]    span_v;
  logic              nonzero;
  logic              upd_p;
  logic              upd_f;

  // Read request toward the range store
  assign issue   = (state_q == S_RUN) && (idx_q < count_i);
  assign re_o    = issue;
  assign raddr_o = idx_q[ADDR_W-1:0];

  // Candidate evaluation on the returned range; span keeps the borrow bit so
  // a malformed range compares as a very large span
  assign first_v = rdata_i[2*OFF_W-1:OFF_W];
  assign last_v  = rdata_i[OFF_W-1:0];
  assign span_v  = {1'b0, last_v} - {1'b0, first_v};
  assign nonzero = (first_v != '0) || (last_v != '0);

  assign upd_p = rv_q && nonzero && (last_v <= off_q) && (last_v >= pend_q) &&
                 ((last_v > pend_q) || (pfound_q && (span_v < pspan_q)));
  assign upd_f = rv_q && nonzero && ({1'b0, first_v} >= end_q) &&
                 (!ffound_q || (first_v < fstart_q) ||
                  ((first_v == fstart_q) && (span_v < fspan_q)));

  // Sequencer and best-candidate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      rv_q     <= 1'b0;
      rid_q    <= '0;
      off_q    <= '0;
      end_q    <= '0;
      pfound_q <= 1'b0;
      pend_q   <= '0;
      pspan_q  <= '0;
      pid_q    <= '0;
      ffound_q <= 1'b0;
      fstart_q <= '0;
      fspan_q  <= '0;
      fid_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          rv_q <= 1'b0;
          if (start_i) begin
            state_q  <= S_RUN;
            idx_q    <= '0;
            off_q    <= off_i;
            end_q    <= end_i;
            pfound_q <= 1'b0;
            pend_q   <= '0;
            ffound_q <= 1'b0;
            pid_q    <= '0;
            fid_q    <= '0;
          end
        end
        S_RUN: begin
          rv_q  <= issue;
          rid_q <= idx_q[ADDR_W-1:0];
          if (issue) begin
            idx_q <= idx_q + CNT_W'(1);
          end
          if (upd_p) begin
            pfound_q <= 1'b1;
            pend_q   <= last_v;
            pspan_q  <= span_v;
            pid_q    <= rid_q;
          end
          if (upd_f) begin
            ffound_q <= 1'b1;
            fstart_q <= first_v;
            fspan_q  <= span_v;
            fid_q    <= rid_q;
          end
          if (!issue && !rv_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o.busy     = (state_q != S_IDLE);
  assign status_o.done     = (state_q == S_DONE);
  assign status_o.has_prec = pfound_q;
  assign status_o.has_foll = ffound_q;
  assign prec_id_o         = pid_q;
  assign foll_id_o         = fid_q;

endmodule

/* bench/comment_owner_attach_top_tb.sv */
// Self-checking bench for comment_owner_attach_top: directed table, then random statements.
// Depends on coa_pkg and the block's RTL; owners are predicted by a local model of the block.
`timescale 1ns / 1ps

module comment_owner_attach_top_tb;

  // Sizes and codes taken from the package
  localparam int unsigned ID_W      = coa_pkg::ID_W;
  localparam int unsigned MAX_NODES = coa_pkg::MAX_NODES;
  localparam logic [1:0] CMD_CLEAR   = coa_pkg::CMD_CLEAR;
  localparam logic [1:0] CMD_LOAD    = coa_pkg::CMD_LOAD;
  localparam logic [1:0] CMD_TOKEN   = coa_pkg::CMD_TOKEN;
  localparam logic [1:0] CLS_REAL    = coa_pkg::CLS_REAL;
  localparam logic [1:0] CLS_SPACE   = coa_pkg::CLS_SPACE;
  localparam logic [1:0] CLS_COMMENT = coa_pkg::CLS_COMMENT;

  // Codes the package leaves unnamed
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [1:0] CLS_SPARE = 2'd3;
  localparam bit KNOWN = 1'b1;
  localparam bit FREE  = 1'b0;
  localparam int unsigned ITEM_TARGET = 580;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] first;
    logic [15:0] last;
    logic [1:0]  cls;
    logic [15:0] offset;
    logic [15:0] length;
    logic        nl;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] owner;
    logic            trailing;
  } owner_t;

  typedef struct packed {
    req_t   req;
    logic   fixed;
    owner_t want;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [ID_W-1:0] cfg_root_node_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [1:0]      cmd_i = CMD_CLEAR;
  logic [15:0]     range_first_i = '0;
  logic [15:0]     range_last_i = '0;
  logic [1:0]      token_class_i = CLS_REAL;
  logic [15:0]     token_offset_i = '0;
  logic [15:0]     token_length_i = '0;
  logic            token_has_newline_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [ID_W-1:0] owner_node_o;
  logic            is_trailing_o;

  // Local copy of the block state
  logic [15:0]     nm_first [MAX_NODES];
  logic [15:0]     nm_last  [MAX_NODES];
  int unsigned     nm_count = 0;
  bit              had_real = 1'b0;
  bit              nl_gap = 1'b0;
  logic [ID_W-1:0] root_model = '0;

  owner_t      pending_owners [$];
  row_t        plan [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          no_idle = 1'b0;

  comment_owner_attach_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_root_node_i     (cfg_root_node_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .cmd_i               (cmd_i),
    .range_first_i       (range_first_i),
    .range_last_i        (range_last_i),
    .token_class_i       (token_class_i),
    .token_offset_i      (token_offset_i),
    .token_length_i      (token_length_i),
    .token_has_newline_i (token_has_newline_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .owner_node_o        (owner_node_o),
    .is_trailing_o       (is_trailing_o)
  );

  always #6 clk_i = ~clk_i;

  // Run limit, far above the slowest legal run
  initial begin : watchdog
    #(12 * 4000000);
    $display("Mismatches found");
    $finish;
  end

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  // Apply one request to the local state; returns 1 when a comment owner results
  function automatic bit resolve_owner(input req_t r, output owner_t res);
    bit              trailing;
    bit              has_prec;
    bit              has_foll;
    logic [ID_W-1:0] prec;
    logic [ID_W-1:0] foll;
    logic [15:0]     prec_end;
    logic [15:0]     foll_start;
    logic [31:0]     prec_span;
    logic [31:0]     foll_span;
    logic [31:0]     sp;
    logic [16:0]     tok_end;
    int unsigned     n;
    res = '0;
    case (r.cmd)
      CMD_CLEAR: begin
        nm_count = 0;
        had_real = 1'b0;
        nl_gap = 1'b0;
        return 1'b0;
      end
      CMD_LOAD: begin
        // loads past a full store are dropped
        if (nm_count < MAX_NODES) begin
          nm_first[nm_count] = r.first;
          nm_last[nm_count] = r.last;
          nm_count++;
        end
        return 1'b0;
      end
      CMD_TOKEN: ;
      default: return 1'b0;
    endcase
    if (r.cls == CLS_SPACE) begin
      if (r.nl) nl_gap = 1'b1;
      return 1'b0;
    end
    // the spare class counts as a real token
    if (r.cls != CLS_COMMENT) begin
      had_real = 1'b1;
      nl_gap = 1'b0;
      return 1'b0;
    end
    trailing = had_real && !nl_gap;
    if (r.nl) nl_gap = 1'b1;
    tok_end = {1'b0, r.offset} + {1'b0, r.length};
    has_prec = 1'b0;
    has_foll = 1'b0;
    prec = '0;
    foll = '0;
    prec_end = '0;
    foll_start = '0;
    prec_span = '0;
    foll_span = '0;
    // one pass, both neighbor searches; all-zero ranges are skipped
    for (n = 0; n < nm_count; n++) begin
      if (nm_first[n] == 16'd0 && nm_last[n] == 16'd0) continue;
      sp = {16'd0, nm_last[n]} - {16'd0, nm_first[n]};
      if (nm_last[n] <= r.offset && nm_last[n] >= prec_end) begin
        if (nm_last[n] > prec_end || (has_prec && sp < prec_span)) begin
          prec_end = nm_last[n];
          prec = n[ID_W-1:0];
          prec_span = sp;
          has_prec = 1'b1;
        end
      end
      if ({1'b0, nm_first[n]} >= tok_end) begin
        if (!has_foll || nm_first[n] < foll_start ||
            (nm_first[n] == foll_start && sp < foll_span)) begin
          foll_start = nm_first[n];
          foll = n[ID_W-1:0];
          foll_span = sp;
          has_foll = 1'b1;
        end
      end
    end
    res.owner = (has_prec && has_foll) ? (trailing ? prec : foll) : root_model;
    res.trailing = trailing;
    return 1'b1;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.cmd = 2'($urandom_range(3));
    r.first = 16'($urandom);
    r.last = 16'($urandom);
    r.cls = 2'($urandom_range(3));
    r.offset = 16'($urandom);
    r.length = 16'($urandom);
    r.nl = 1'($urandom);
    return r;
  endfunction

  // Hand one request to the block, then record what it should produce
  task automatic push_request(input req_t r, input bit fixed, input owner_t want);
    owner_t res;
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i <= r.cmd;
    range_first_i <= r.first;
    range_last_i <= r.last;
    token_class_i <= r.cls;
    token_offset_i <= r.offset;
    token_length_i <= r.length;
    token_has_newline_i <= r.nl;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (r.cmd != CMD_SPARE) items_sent++;
    if (resolve_owner(r, res)) begin
      pending_owners.push_back(fixed ? want : res);
    end
  endtask

  task automatic send(input req_t r);
    push_request(r, FREE, '0);
  endtask

  // Stray requests between well-formed ones
  task automatic send_with_noise(input req_t r);
    if ($urandom_range(99) < 7) send(random_req());
    send(r);
  endtask

  // Drop valid, wait for every owner to arrive, then let the block drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_owners.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_root(input logic [ID_W-1:0] v);
    settle();
    cfg_root_node_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    root_model = v;
  endtask

  task automatic add_row(input logic [1:0] cmd, input int unsigned first,
                         input int unsigned last, input logic [1:0] cls,
                         input int unsigned offset, input int unsigned length,
                         input bit nl, input bit fixed, input int unsigned owner,
                         input bit trailing);
    row_t row;
    row.req.cmd = cmd;
    row.req.first = 16'(first);
    row.req.last = 16'(last);
    row.req.cls = cls;
    row.req.offset = 16'(offset);
    row.req.length = 16'(length);
    row.req.nl = nl;
    row.fixed = fixed;
    row.want.owner = ID_W'(owner);
    row.want.trailing = trailing;
    plan.push_back(row);
  endtask

  // Directed table; root_node still holds its reset value here
  task automatic build_plan();
    //      cmd        first  last   class        offset length nl fixed  owner trl
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 0,     0,     0, KNOWN, 0,    0);
    add_row(CMD_SPARE, 65535, 65535, CLS_SPARE,   65535, 65535, 1, FREE,  0,    0);
    add_row(CMD_LOAD,  0,     0,     CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_LOAD,  10,    20,    CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_LOAD,  30,    40,    CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_LOAD,  10,    20,    CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_LOAD,  5,     25,    CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_LOAD,  50,    40,    CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_LOAD,  65535, 65535, CLS_REAL,    0,     0,     0, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_REAL,    0,     10,    0, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 22,    3,     0, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_SPACE,   25,    5,     1, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 30,    2,     0, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_SPARE,   65535, 65535, 1, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 65535, 65535, 1, KNOWN, 0,    1);
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 0,     0,     0, KNOWN, 0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_SPACE,   65535, 65535, 0, FREE,  0,    0);
    add_row(CMD_CLEAR, 65535, 65535, CLS_SPARE,   65535, 65535, 1, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 100,   1,     0, KNOWN, 0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_REAL,    101,   2,     0, FREE,  0,    0);
    add_row(CMD_TOKEN, 0,     0,     CLS_COMMENT, 103,   4,     1, KNOWN, 0,    1);
  endtask

  // One statement: usually a clear, node ranges mostly on token boundaries, then tiled tokens
  task automatic run_statement();
    req_t        toks [$];
    int unsigned edges [$];
    req_t        r;
    int unsigned pos;
    int unsigned n_tok;
    int unsigned n_node;
    int unsigned a;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    pos = ($urandom_range(9) < 8) ? $urandom_range(500) : $urandom_range(65300, 65200);
    n_tok = $urandom_range(20, 1);
    edges.push_back(pos);
    for (k = 0; k < n_tok; k++) begin
      r = random_req();
      r.cmd = CMD_TOKEN;
      a = $urandom_range(19);
      r.cls = (a < 9) ? CLS_REAL : (a < 14) ? CLS_SPACE : (a < 19) ? CLS_COMMENT : CLS_SPARE;
      r.offset = 16'(pos);
      r.length = 16'($urandom_range(8));
      r.nl = ($urandom_range(3) == 0);
      pos += r.length;
      edges.push_back(pos);
      toks.push_back(r);
    end
    // now and then the statement runs on without a clear
    if ($urandom_range(9) != 0 || nm_count > 200) begin
      r = random_req();
      r.cmd = CMD_CLEAR;
      send(r);
    end
    n_node = $urandom_range(24);
    for (k = 0; k < n_node; k++) begin
      r = random_req();
      r.cmd = CMD_LOAD;
      a = $urandom_range(9);
      i = $urandom_range(edges.size() - 1);
      j = $urandom_range(edges.size() - 1, i);
      if (a == 0) begin
        r.first = '0;
        r.last = '0;
      end else if (a == 1) begin
        // reversed range, span wraps
        r.first = 16'(edges[j]);
        r.last = 16'(edges[i]);
      end else if (a > 2) begin
        r.first = 16'(edges[i]);
        r.last = 16'(edges[j]);
      end
      send_with_noise(r);
    end
    foreach (toks[t]) send_with_noise(toks[t]);
  endtask

  // Result side: random stall, compare each owner with the oldest prediction
  always @(posedge clk_i) begin : collect
    owner_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_owners.size() == 0) begin
          note_error($sformatf("unexpected result: owner %0d trailing %0b",
                               owner_node_o, is_trailing_o));
        end else begin
          want = pending_owners.pop_front();
          if (owner_node_o !== want.owner || is_trailing_o !== want.trailing) begin
            note_error($sformatf("owner %0d trailing %0b, expected owner %0d trailing %0b",
                                 owner_node_o, is_trailing_o, want.owner, want.trailing));
          end
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < 21);
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned s;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_plan();
    foreach (plan[k]) push_request(plan[k].req, plan[k].fixed, plan[k].want);
    ph = 0;
    while (items_sent < ITEM_TARGET) begin
      set_root(ph == 0 ? 10'd1023 : ph == 1 ? 10'd0 : 10'($urandom_range(1023)));
      // third phase runs with neither side idling
      no_idle = (ph == 2);
      for (s = 0; s < 5 && items_sent < ITEM_TARGET; s++) run_statement();
      ph++;
    end
    no_idle = 1'b0;
    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
sv/coa_pkg.sv
sv/coa_mem.sv
sv/coa_scan.sv
sv/comment_owner_attach_top.sv
bench/comment_owner_attach_top_tb.sv
